@@ rtl/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and fixed constants of the burst byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int LANES   = 8;
    localparam int LANE_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int DATA_W  = 64;
    localparam int FILL_W  = 9;

    localparam int BUFFER_DEPTH = 256;
    localparam int ROWS         = BUFFER_DEPTH / LANES;
    localparam int ROW_W        = $clog2(ROWS);

    localparam logic [COUNT_W-1:0] MAX_BURST = 4'd8;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic                accepted;
        logic                rd_ok;
        logic [LANE_W-1:0]   lo;
        logic [COUNT_W-1:0]  count;
        logic [FILL_W-1:0]   fill;
    } t_s2_info;

endpackage

@@ rtl/brb_ram.sv @@
// ----------------------------------------------------------------------------
// brb_ram
// Single-port RAM with enable, write enable and registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/brb_ctrl.sv @@
// ----------------------------------------------------------------------------
// brb_ctrl
// Request register, admission check, pointer and fill tracking, and the
// address and write steering for the eight byte banks.
// ----------------------------------------------------------------------------
module brb_ctrl
    import brb_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_req_type,
    input  logic [COUNT_W-1:0]                 i_byte_count,
    input  logic [DATA_W-1:0]                  i_write_bytes,
    input  logic                               i_s2_free,
    output logic                               o_s1_fire,
    output t_s2_info                           o_info,
    output logic                               o_bank_en,
    output logic [LANES-1:0]                   o_bank_we,
    output logic [LANES-1:0][ROW_W-1:0]        o_bank_addr,
    output logic [LANES-1:0][BYTE_W-1:0]       o_bank_wdata
);

    localparam int PTR_W  = ROW_W + LANE_W;
    localparam int HELD_W = $clog2(BUFFER_DEPTH + 1);

    logic                r_s1_valid;
    logic                r_type;
    logic [COUNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0]   r_wdata;
    logic [PTR_W-1:0]    r_wp;
    logic [PTR_W-1:0]    r_rp;
    logic [HELD_W-1:0]   r_held;

    logic [PTR_W-1:0]    n_wp;
    logic [PTR_W-1:0]    n_rp;
    logic [HELD_W-1:0]   n_held;

    logic                s1_free;
    logic                cnt_ok;
    logic                wr_ok;
    logic                rd_ok;
    logic [HELD_W:0]     wr_sum;
    logic [LANE_W-1:0]   wr_idx [LANES];
    logic [ROW_W-1:0]    wr_row [LANES];
    logic [ROW_W-1:0]    rd_row [LANES];

    assign s1_free   = !r_s1_valid || i_s2_free;
    assign o_stall   = !s1_free;
    assign o_s1_fire = r_s1_valid && i_s2_free;

    assign cnt_ok = (r_cnt != '0) && (r_cnt <= MAX_BURST);
    assign wr_sum = (HELD_W+1)'(r_held) + (HELD_W+1)'(r_cnt);
    assign wr_ok  = cnt_ok && (r_type == REQ_WRITE)
                    && (wr_sum <= (HELD_W+1)'(BUFFER_DEPTH));
    assign rd_ok  = cnt_ok && (r_type == REQ_READ)
                    && ((HELD_W+1)'(r_cnt) <= (HELD_W+1)'(r_held));

    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_held = r_held;
        if (wr_ok) begin
            n_wp   = r_wp + PTR_W'(r_cnt);
            n_held = r_held + HELD_W'(r_cnt);
        end else if (rd_ok) begin
            n_rp   = r_rp + PTR_W'(r_cnt);
            n_held = r_held - HELD_W'(r_cnt);
        end
    end

    always_comb begin
        for (int b = 0; b < LANES; b++) begin
            wr_idx[b] = LANE_W'(b) - r_wp[LANE_W-1:0];
            wr_row[b] = r_wp[PTR_W-1:LANE_W]
                        + ROW_W'(LANE_W'(b) < r_wp[LANE_W-1:0]);
            rd_row[b] = r_rp[PTR_W-1:LANE_W]
                        + ROW_W'(LANE_W'(b) < r_rp[LANE_W-1:0]);
            o_bank_we[b]    = o_s1_fire && wr_ok && (COUNT_W'(wr_idx[b]) < r_cnt);
            o_bank_addr[b]  = (r_type == REQ_READ) ? rd_row[b] : wr_row[b];
            o_bank_wdata[b] = r_wdata[BYTE_W*wr_idx[b] +: BYTE_W];
        end
    end

    assign o_bank_en = o_s1_fire;

    assign o_info.accepted = wr_ok || rd_ok;
    assign o_info.rd_ok    = rd_ok;
    assign o_info.lo       = r_rp[LANE_W-1:0];
    assign o_info.count    = r_cnt;
    assign o_info.fill     = FILL_W'(n_held);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_held     <= '0;
        end else begin
            if (i_valid && s1_free) begin
                r_s1_valid <= 1'b1;
            end else if (o_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (o_s1_fire) begin
                r_wp   <= n_wp;
                r_rp   <= n_rp;
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_free) begin
            r_type  <= i_req_type;
            r_cnt   <= i_byte_count;
            r_wdata <= i_write_bytes;
        end
    end

endmodule

@@ rtl/brb_out.sv @@
// ----------------------------------------------------------------------------
// brb_out
// Read-data stage: realigns bank data to request order, zeroes unused bytes
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module brb_out
    import brb_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s1_fire,
    input  t_s2_info                      i_info,
    input  logic [LANES-1:0][BYTE_W-1:0]  i_bank_rdata,
    output logic                          o_s2_free,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_accepted,
    output logic [DATA_W-1:0]             o_read_bytes,
    output logic [FILL_W-1:0]             o_fill_level
);

    logic                r_s2_valid;
    t_s2_info            r_s2;
    logic                r_o_valid;
    logic                r_accepted;
    logic [DATA_W-1:0]   r_read_bytes;
    logic [FILL_W-1:0]   r_fill;

    logic                out_free;
    logic                s2_fire;
    logic [DATA_W-1:0]   rdata;
    logic [LANE_W-1:0]   sel [LANES];

    assign out_free  = !r_o_valid || !i_stall;
    assign s2_fire   = r_s2_valid && out_free;
    assign o_s2_free = !r_s2_valid || out_free;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            sel[i] = r_s2.lo + LANE_W'(i);
            rdata[BYTE_W*i +: BYTE_W] =
                (r_s2.rd_ok && (COUNT_W'(i) < r_s2.count)) ? i_bank_rdata[sel[i]] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_s1_fire) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_fire) begin
            r_s2 <= i_info;
        end
        if (s2_fire) begin
            r_accepted   <= r_s2.accepted;
            r_read_bytes <= rdata;
            r_fill       <= r_s2.fill;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_accepted   = r_accepted;
    assign o_read_bytes = r_read_bytes;
    assign o_fill_level = r_fill;

endmodule

@@ rtl/byte_ring_buffer_burst_core.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst_core
// Circular byte FIFO taking all-or-nothing write and read bursts.
//
// Request channel (i_valid / o_stall): a write burst stores i_byte_count
// bytes of i_write_bytes, first byte in bits 7:0; a read burst returns that
// many bytes. A burst of zero or more than eight bytes, a write that does not
// fit the free space and a read larger than the fill level are rejected and
// change nothing. Every request yields one result on the result channel
// (o_valid / i_stall): accept flag, read bytes (unused bytes zero) and fill.
// Throughput is one request per cycle while i_stall does not hold the pipeline.
// A result passes the input register, the bank read register and the output
// register before it is valid at the outputs.
// Storage is eight byte-wide banks, one byte lane each, so a burst touches
// every bank at most once.
// Reset empties the buffer and the pipeline; no clearing pass is needed.
// A stalled result holds in the output register; stall backs up through the
// pipeline to o_stall, and the buffer state moves only when a request
// advances out of the input register.
// ----------------------------------------------------------------------------
module byte_ring_buffer_burst_core
    import brb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_req_type,
    input  logic [COUNT_W-1:0]  i_byte_count,
    input  logic [DATA_W-1:0]   i_write_bytes,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_accepted,
    output logic [DATA_W-1:0]   o_read_bytes,
    output logic [FILL_W-1:0]   o_fill_level
);

    logic                           s1_fire;
    logic                           s2_free;
    t_s2_info                       s1_info;
    logic                           bank_en;
    logic [LANES-1:0]               bank_we;
    logic [LANES-1:0][ROW_W-1:0]    bank_addr;
    logic [LANES-1:0][BYTE_W-1:0]   bank_wdata;
    logic [LANES-1:0][BYTE_W-1:0]   bank_rdata;

    brb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_byte_count  (i_byte_count),
        .i_write_bytes (i_write_bytes),
        .i_s2_free     (s2_free),
        .o_s1_fire     (s1_fire),
        .o_info        (s1_info),
        .o_bank_en     (bank_en),
        .o_bank_we     (bank_we),
        .o_bank_addr   (bank_addr),
        .o_bank_wdata  (bank_wdata)
    );

    for (genvar b = 0; b < LANES; b++) begin : g_bank
        brb_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (bank_en),
            .i_we    (bank_we[b]),
            .i_addr  (bank_addr[b]),
            .i_wdata (bank_wdata[b]),
            .o_rdata (bank_rdata[b])
        );
    end

    brb_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_fire    (s1_fire),
        .i_info       (s1_info),
        .i_bank_rdata (bank_rdata),
        .o_s2_free    (s2_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_accepted   (o_accepted),
        .o_read_bytes (o_read_bytes),
        .o_fill_level (o_fill_level)
    );

    a_reject_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_read_bytes == '0)
        else $error("rejected request returned read data");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_fill_level) <= BUFFER_DEPTH)
        else $error("fill level above buffer depth");

    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && s1_info.accepted |-> s1_info.count != '0 && s1_info.count <= MAX_BURST)
        else $error("burst accepted with illegal byte count");

    a_write_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|bank_we) |-> s1_fire && !s1_info.rd_ok)
        else $error("bank write outside an accepted write burst");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for byte_ring_buffer_burst_core. A shadow copy of the
// ring (byte store, pointers, fill count) predicts accept flag, read bytes
// and fill level for every request transaction taken by the core. Each
// result transaction is compared in order against the oldest prediction.
// Stimulus is a directed opening (zero, oversize and underflow bursts, byte
// extremes, lane wrap) followed by random fill and drain
// sweeps that repeatedly hit the full and empty boundaries, with random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top
    import brb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = BUFFER_DEPTH;
    localparam int RANDOM_ITEMS = 730;
    localparam int CALM_ITEMS   = 100;

    typedef struct packed {
        logic               accepted;
        logic [DATA_W-1:0]  read_bytes;
        logic [FILL_W-1:0]  fill_level;
    } t_burst_result;

    class ring_buffer_tracker;
        logic [BYTE_W-1:0] byte_mem [DEPTH];
        int unsigned       wr_ptr;
        int unsigned       rd_ptr;
        int unsigned       held;
        t_burst_result     pending_results [$];
        int unsigned       errors;

        function void note_request(logic kind, logic [COUNT_W-1:0] count,
                                   logic [DATA_W-1:0] wdata);
            t_burst_result r;
            int unsigned   n;
            int unsigned   i;
            r = '0;
            n = count;
            if (n != 0 && n <= MAX_BURST) begin
                if (kind == REQ_WRITE) begin
                    if (n <= DEPTH - held) begin
                        for (i = 0; i < n; i++) begin
                            byte_mem[(wr_ptr + i) % DEPTH] = wdata[8*i +: 8];
                        end
                        wr_ptr = (wr_ptr + n) % DEPTH;
                        held += n;
                        r.accepted = 1'b1;
                    end
                end else begin
                    if (n <= held) begin
                        for (i = 0; i < n; i++) begin
                            r.read_bytes[8*i +: 8] = byte_mem[(rd_ptr + i) % DEPTH];
                        end
                        rd_ptr = (rd_ptr + n) % DEPTH;
                        held -= n;
                        r.accepted = 1'b1;
                    end
                end
            end
            r.fill_level = held[FILL_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic acc, logic [DATA_W-1:0] rd,
                                   logic [FILL_W-1:0] fill);
            t_burst_result e;
            if (pending_results.size() == 0) begin
                $error("result transaction with no request outstanding");
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (acc !== e.accepted) begin
                $error("accepted mismatch: expected %0b, actual %0b", e.accepted, acc);
                errors++;
            end
            if (rd !== e.read_bytes) begin
                $error("read_bytes mismatch: expected %h, actual %h", e.read_bytes, rd);
                errors++;
            end
            if (fill !== e.fill_level) begin
                $error("fill_level mismatch: expected %0d, actual %0d",
                       e.fill_level, fill);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic                i_req_type    = REQ_WRITE;
    logic [COUNT_W-1:0]  i_byte_count  = '0;
    logic [DATA_W-1:0]   i_write_bytes = '0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic                o_accepted;
    logic [DATA_W-1:0]   o_read_bytes;
    logic [FILL_W-1:0]   o_fill_level;

    ring_buffer_tracker  tracker = new();
    bit                  quiet   = 1'b0;

    byte_ring_buffer_burst_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_byte_count  (i_byte_count),
        .i_write_bytes (i_write_bytes),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_accepted    (o_accepted),
        .o_read_bytes  (o_read_bytes),
        .o_fill_level  (o_fill_level)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_result(o_accepted, o_read_bytes, o_fill_level);
        end
    end

    // receiver back-pressure in bursts
    initial begin
        while (!quiet) begin
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_request(input logic kind, input logic [COUNT_W-1:0] count,
                                input logic [DATA_W-1:0] data, input bit idle_ok);
        if (idle_ok && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= kind;
        i_byte_count  <= count;
        i_write_bytes <= data;
        do @(posedge i_clk); while (o_stall);
        tracker.note_request(kind, count, data);
    endtask

    task automatic send_random_burst(input bit idle_ok, inout bit draining);
        logic               kind;
        logic [COUNT_W-1:0] count;
        int unsigned        pick;
        if (!draining && DEPTH - tracker.held < MAX_BURST && $urandom_range(0, 3) == 0) begin
            draining = 1'b1;
        end else if (draining && tracker.held < MAX_BURST && $urandom_range(0, 3) == 0) begin
            draining = 1'b0;
        end
        if ($urandom_range(0, 99) < 85) begin
            kind = draining ? REQ_READ : REQ_WRITE;
        end else begin
            kind = draining ? REQ_WRITE : REQ_READ;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            count = '0;
        end else if (pick == 1) begin
            count = COUNT_W'($urandom_range(9, 15));
        end else begin
            count = COUNT_W'($urandom_range(1, 8));
        end
        send_request(kind, count, {$urandom, $urandom}, idle_ok);
    endtask

    initial begin
        bit draining;
        draining = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_WRITE, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(REQ_READ,  4'd0,  64'h0, 1'b1);
        send_request(REQ_READ,  4'd1,  64'h0, 1'b1);
        send_request(REQ_WRITE, 4'd9,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(REQ_WRITE, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(REQ_WRITE, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(REQ_WRITE, 4'd8,  64'h0, 1'b1);
        send_request(REQ_WRITE, 4'd1,  64'hFFFF_FFFF_FFFF_FFA5, 1'b1);
        send_request(REQ_READ,  4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(REQ_READ,  4'd9,  64'h0, 1'b1);
        send_request(REQ_READ,  4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(REQ_READ,  4'd8,  64'h0, 1'b1);
        send_request(REQ_READ,  4'd2,  64'h0, 1'b1);
        send_request(REQ_READ,  4'd1,  64'h0, 1'b1);
        send_request(REQ_READ,  4'd1,  64'h0, 1'b1);
        send_request(REQ_WRITE, 4'd8,  64'h8877_6655_4433_2211, 1'b1);
        send_request(REQ_WRITE, 4'd3,  64'hFFFF_FFFF_FFCC_BBAA, 1'b1);
        send_request(REQ_READ,  4'd5,  64'h0, 1'b1);
        send_request(REQ_READ,  4'd7,  64'h0, 1'b1);
        send_request(REQ_READ,  4'd6,  64'h0, 1'b1);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - CALM_ITEMS) begin
                quiet = 1'b1;
            end
            send_random_burst(k < RANDOM_ITEMS - CALM_ITEMS, draining);
        end
        i_valid <= 1'b0;

        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
